>>> hw/rtl/asmon_pkg.sv
// Activation sparsity monitor package: sizes, queue operation format and
// accumulator record shared by the front, queue, back and checker modules.
// No dependencies.
package asmon_pkg;

  localparam int MAX_LAYERS  = 64;
  // Block size must be a power of two; block counts come from a shift.
  localparam int BLOCK_SIZE  = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam int CNT_W    = 32;
  localparam int ACC_W    = 64;
  localparam int LAYER_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int SEEN_OUT_W = 7;
  localparam int LAYER_AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int FILL_W   = $clog2(BLOCK_SIZE);
  localparam int BLOCKS_W = CNT_W + 1 - FILL_W;
  localparam int SEEN_W   = $clog2(MAX_LAYERS + 1);
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_ELEMENT = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  typedef enum logic [1:0] {
    OP_COMMIT   = 2'd0,
    OP_READ     = 2'd1,
    OP_OVERFLOW = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic                  in_range;
    logic [LAYER_AW-1:0]   addr;
    logic [CNT_W-1:0]      zeros;
    logic [CNT_W-1:0]      elems;
    logic [CNT_W-1:0]      zblocks;
    logic [BLOCKS_W-1:0]   blocks;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_wr_t;

  typedef struct packed {
    logic [ACC_W-1:0] zeros;
    logic [ACC_W-1:0] elems;
    logic [ACC_W-1:0] zblocks;
    logic [ACC_W-1:0] blocks;
  } acc_t;

  function automatic logic is_fp_zero(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-2:0] == '0;
  endfunction

endpackage

>>> hw/rtl/asmon_front.sv
// Front part of the sparsity monitor: holds the enable register, takes input
// transfers, counts zeros and blocks of the open buffer and issues operations.
// Depends on asmon_pkg.
module asmon_front import asmon_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [LAYER_W-1:0] layer,
  input  logic [VALUE_W-1:0] value,
  input  logic               last_element,
  input  logic               q_full,
  output q_wr_t              q_wr
);

  logic              enable;
  logic [CNT_W-1:0]  buf_zeros, buf_zeros_next;
  logic [CNT_W-1:0]  buf_elems, buf_elems_next;
  logic [CNT_W-1:0]  buf_zblocks, buf_zblocks_next;
  logic [FILL_W-1:0] blk_fill, blk_fill_next;
  logic              blk_all_zero, blk_all_zero_next;

  logic              accept;
  logic              in_range;
  logic              zero_in;
  logic              blk_closes;
  logic              all_zero_inc;
  logic [CNT_W-1:0]  elems_inc;
  logic [CNT_W-1:0]  zeros_inc;
  logic [CNT_W-1:0]  zblocks_inc;
  logic [CNT_W:0]    blocks_sum;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_range = !layer[LAYER_W-1] && (layer < LAYER_W'(MAX_LAYERS));
  assign zero_in  = is_fp_zero(value);

  assign elems_inc    = buf_elems + CNT_W'(1);
  assign zeros_inc    = buf_zeros + CNT_W'(zero_in);
  assign blk_closes   = last_element || (blk_fill == FILL_W'(BLOCK_SIZE - 1));
  assign all_zero_inc = zero_in && ((blk_fill == '0) || blk_all_zero);
  assign zblocks_inc  = buf_zblocks + CNT_W'(blk_closes && all_zero_inc);
  assign blocks_sum   = {1'b0, elems_inc} + (CNT_W + 1)'(BLOCK_SIZE - 1);

  always_comb begin
    buf_zeros_next    = buf_zeros;
    buf_elems_next    = buf_elems;
    buf_zblocks_next  = buf_zblocks;
    blk_fill_next     = blk_fill;
    blk_all_zero_next = blk_all_zero;
    q_wr.valid        = 1'b0;
    q_wr.op.kind      = OP_READ;
    q_wr.op.in_range  = in_range;
    q_wr.op.addr      = layer[LAYER_AW-1:0];
    q_wr.op.zeros     = zeros_inc;
    q_wr.op.elems     = elems_inc;
    q_wr.op.zblocks   = zblocks_inc;
    q_wr.op.blocks    = blocks_sum[CNT_W:FILL_W];
    if (accept) begin
      if (mode == MODE_READ) begin
        q_wr.valid   = 1'b1;
        q_wr.op.kind = OP_READ;
      end else if (enable) begin
        if (in_range) begin
          if (last_element) begin
            q_wr.valid   = 1'b1;
            q_wr.op.kind = OP_COMMIT;
          end
          buf_zeros_next    = last_element ? '0 : zeros_inc;
          buf_elems_next    = last_element ? '0 : elems_inc;
          buf_zblocks_next  = last_element ? '0 : zblocks_inc;
          blk_fill_next     = blk_closes ? '0 : blk_fill + FILL_W'(1);
          blk_all_zero_next = all_zero_inc;
        end else begin
          if (!layer[LAYER_W-1]) begin
            q_wr.valid   = 1'b1;
            q_wr.op.kind = OP_OVERFLOW;
          end
          if (last_element) begin
            buf_zeros_next   = '0;
            buf_elems_next   = '0;
            buf_zblocks_next = '0;
            blk_fill_next    = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      buf_zeros    <= '0;
      buf_elems    <= '0;
      buf_zblocks  <= '0;
      blk_fill     <= '0;
      blk_all_zero <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_wdata;
      end
      buf_zeros    <= buf_zeros_next;
      buf_elems    <= buf_elems_next;
      buf_zblocks  <= buf_zblocks_next;
      blk_fill     <= blk_fill_next;
      blk_all_zero <= blk_all_zero_next;
    end
  end

endmodule

>>> hw/rtl/asmon_queue.sv
// Operation queue between the monitor front and back parts.
// Register-based FIFO of QUEUE_DEPTH entries. Depends on asmon_pkg.
module asmon_queue import asmon_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t q_wr,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output op_t   head_op
);

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_wr.valid) begin
      entries[wr_ptr] <= q_wr.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (q_wr.valid && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (!q_wr.valid && pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/asmon_back.sv
// Back part of the sparsity monitor: per-layer 64-bit accumulator memory,
// commit and read execution, highest-layer and overflow tracking, output
// register. Depends on asmon_pkg.
module asmon_back import asmon_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  op_t                   head_op,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ACC_W-1:0]      zero_count,
  output logic [ACC_W-1:0]      element_total,
  output logic [ACC_W-1:0]      zero_block_count,
  output logic [ACC_W-1:0]      block_total,
  output logic [SEEN_OUT_W-1:0] layers_seen,
  output logic                  overflow_seen
);

  acc_t                acc_mem [MAX_LAYERS];
  logic [MAX_LAYERS-1:0] acc_vld;

  logic                s2_valid;
  op_t                 s2_op;
  acc_t                s2_rd;
  logic                s2_hit;

  logic                wr_valid;
  logic [LAYER_AW-1:0] wr_addr;
  acc_t                wr_data;

  logic [SEEN_W-1:0]   highest;
  logic [SEEN_W-1:0]   layer_next;
  logic                ovf;

  logic                out_free;
  logic                s2_leaves;
  logic                s2_ready;
  logic                commit_wr;
  logic                read_done;
  acc_t                cur;
  acc_t                sum;

  assign out_free  = !out_valid || !out_stall;
  assign s2_leaves = s2_valid && ((s2_op.kind != OP_READ) || out_free);
  assign s2_ready  = !s2_valid || s2_leaves;
  assign pop       = head_valid && s2_ready;
  assign commit_wr = s2_leaves && (s2_op.kind == OP_COMMIT);
  assign read_done = s2_leaves && (s2_op.kind == OP_READ);
  assign layer_next = SEEN_W'(s2_op.addr) + SEEN_W'(1);

  always_comb begin
    if (wr_valid && (wr_addr == s2_op.addr)) begin
      cur = wr_data;
    end else if (s2_hit) begin
      cur = s2_rd;
    end else begin
      cur = '0;
    end
    sum.zeros   = cur.zeros   + ACC_W'(s2_op.zeros);
    sum.elems   = cur.elems   + ACC_W'(s2_op.elems);
    sum.zblocks = cur.zblocks + ACC_W'(s2_op.zblocks);
    sum.blocks  = cur.blocks  + ACC_W'(s2_op.blocks);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_rd <= acc_mem[head_op.addr];
    end
    if (commit_wr) begin
      acc_mem[s2_op.addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_op  <= head_op;
      s2_hit <= acc_vld[head_op.addr];
    end
    if (commit_wr) begin
      wr_addr <= s2_op.addr;
      wr_data <= sum;
    end
    if (read_done) begin
      zero_count       <= s2_op.in_range ? cur.zeros   : '0;
      element_total    <= s2_op.in_range ? cur.elems   : '0;
      zero_block_count <= s2_op.in_range ? cur.zblocks : '0;
      block_total      <= s2_op.in_range ? cur.blocks  : '0;
      layers_seen      <= SEEN_OUT_W'(highest);
      overflow_seen    <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      acc_vld   <= '0;
      wr_valid  <= 1'b0;
      highest   <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s2_valid <= 1'b1;
      end else if (s2_leaves) begin
        s2_valid <= 1'b0;
      end
      if (commit_wr) begin
        acc_vld[s2_op.addr] <= 1'b1;
        wr_valid            <= 1'b1;
        if (layer_next > highest) begin
          highest <= layer_next;
        end
      end
      if (s2_leaves && (s2_op.kind == OP_OVERFLOW)) begin
        ovf <= 1'b1;
      end
      if (read_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/activation_sparsity_monitor.sv
// Activation sparsity monitor, top level: front, operation queue and back.
// Depends on asmon_pkg, asmon_front, asmon_queue and asmon_back.
//
// Usage:
//   Input channel (in_valid/in_stall) carries mode, layer, value and
//   last_element. Element transfers (mode 0) are counted into the open
//   buffer while enable is set; the last element commits the buffer to its
//   layer's 64-bit accumulators. A read transfer (mode 1) yields exactly one
//   result on the output channel (out_valid/out_stall) with that layer's
//   four accumulators, layers_seen and overflow_seen.
//   Write enable through cfg_we/cfg_wdata while the block is idle.
// Timing:
//   One item per cycle sustained while in_stall is low. A read result is
//   registered in the queue, then in the back part's accumulator read stage,
//   then in the output register.
//   A stalled result holds on the output; the back part holds at the next read,
//   and the 4-entry queue keeps taking items until full, when in_stall rises.
// Reset:
//   rst clears enable, the open buffer, all accumulators (per-layer valid
//   bits), the highest-layer count behind layers_seen, the overflow flag and the queue.
module activation_sparsity_monitor import asmon_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [LAYER_W-1:0]    layer,
  input  logic [VALUE_W-1:0]    value,
  input  logic                  last_element,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ACC_W-1:0]      zero_count,
  output logic [ACC_W-1:0]      element_total,
  output logic [ACC_W-1:0]      zero_block_count,
  output logic [ACC_W-1:0]      block_total,
  output logic [SEEN_OUT_W-1:0] layers_seen,
  output logic                  overflow_seen
);

  q_wr_t q_wr;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  op_t   head_op;

  asmon_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .layer        (layer),
    .value        (value),
    .last_element (last_element),
    .q_full       (q_full),
    .q_wr         (q_wr)
  );

  asmon_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .q_wr       (q_wr),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  asmon_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_op          (head_op),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .zero_count       (zero_count),
    .element_total    (element_total),
    .zero_block_count (zero_block_count),
    .block_total      (block_total),
    .layers_seen      (layers_seen),
    .overflow_seen    (overflow_seen)
  );

endmodule

>>> hw/rtl/asmon_checker.sv
// Port-level checker for the activation sparsity monitor, bound to the top.
// Depends on asmon_pkg.
module asmon_checker import asmon_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ACC_W-1:0]      zero_count,
  input logic [ACC_W-1:0]      element_total,
  input logic [ACC_W-1:0]      zero_block_count,
  input logic [ACC_W-1:0]      block_total,
  input logic [SEEN_OUT_W-1:0] layers_seen,
  input logic                  overflow_seen
);

  logic ovf_shown;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_shown <= 1'b0;
    end else if (out_valid && overflow_seen) begin
      ovf_shown <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({zero_count, element_total,
      zero_block_count, block_total, layers_seen, overflow_seen}))
    else $error("stalled result changed");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && ovf_shown |-> overflow_seen)
    else $error("overflow flag cleared after being reported");

  a_seen_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, layers_seen} <= (SEEN_OUT_W + 1)'(MAX_LAYERS)))
    else $error("layers_seen above layer cap");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind activation_sparsity_monitor asmon_checker u_asmon_checker (.*);
